[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion macros, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define TPD_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// condition must never be seen at a clock edge outside reset
`define TPD_ASSERT_NEVER(name, clk, rst_n, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`else

`define TPD_ASSERT(name, clk, rst_n, prop)
`define TPD_ASSERT_NEVER(name, clk, rst_n, cond)

`endif

`endif

[design/tpd_pkg.sv]
// ----------------------------------------------------------------------------
// tpd_pkg
// widths, reset values and register indexes of the threshold peak detector
// ----------------------------------------------------------------------------
`default_nettype none

package tpd_pkg;

    // field widths
    localparam int SAMPLE_W    = 16;
    localparam int INDEX_W     = 32;
    localparam int AVG_W       = 24;
    localparam int FACTOR_W    = 16;
    localparam int CFG_INDEX_W = 2;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_RISE_FACTOR = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FALL_FACTOR = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_AVG_WEIGHT  = 2'd2;

    // register reset values
    localparam logic [FACTOR_W-1:0] RISE_FACTOR_RESET = 16'd1024;
    localparam logic [FACTOR_W-1:0] FALL_FACTOR_RESET = 16'd1638;
    localparam logic [FACTOR_W-1:0] AVG_WEIGHT_RESET  = 16'd66;

    // state reset values: average is -1.0 in Q4.20
    localparam logic signed [AVG_W-1:0]    AVG_RESET = 24'shF00000;
    localparam logic signed [AVG_W-1:0]    AVG_MAX   = 24'sh7FFFFF;
    localparam logic signed [AVG_W-1:0]    AVG_MIN   = 24'sh800000;
    localparam logic signed [SAMPLE_W-1:0] BEST_RESET = 16'sh8000;

    // one detected peak
    typedef struct packed {
        logic [INDEX_W-1:0]         peak_index;
        logic signed [SAMPLE_W-1:0] peak_value;
    } t_result;

endpackage

`default_nettype wire

[design/threshold_peak_detector.sv]
// ----------------------------------------------------------------------------
// threshold_peak_detector
// running-average threshold detector that reports the peak of each excursion
// ----------------------------------------------------------------------------
// Samples (signed Q4.12) arrive on i_valid/o_stall, one transfer per cycle
// when the block is not stalling. Each sample is checked against the running
// average times the rise or fall factor, and the average is then updated.
// When a peak search ends, its index and value leave on o_valid/i_stall.
// A transferred sample waits in the input register until the result buffer
// has room; its result, if any, then goes to that buffer and leaves from its head.
// Throughput: one sample per cycle while o_stall is low, set by the single
// processing stage that holds all per-sample arithmetic (three parallel
// multiplies) between the input register and a two-entry result buffer.
// When the receiver stalls, results collect in the two-entry buffer; once it
// is full and a sample waits in the input register, o_stall goes high until
// the receiver takes a result. o_stall comes from registers only.
// Reset (synchronous, i_rst_n low) restores the register defaults, the
// average to -1.0, the sample count to zero and empties both buffers.
// Configuration writes (i_cfg_we) take effect at once and are meant for idle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module threshold_peak_detector
    import tpd_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // configuration write port
    input  wire logic                       i_cfg_we,
    input  wire logic [CFG_INDEX_W-1:0]     i_cfg_index,
    input  wire logic [FACTOR_W-1:0]        i_cfg_data,
    // sample channel
    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire logic signed [SAMPLE_W-1:0] i_sample,
    // peak channel
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output logic [INDEX_W-1:0]              o_peak_index,
    output logic signed [SAMPLE_W-1:0]      o_peak_value
);

    // configuration registers
    logic [FACTOR_W-1:0] r_rise_factor;
    logic [FACTOR_W-1:0] r_fall_factor;
    logic [FACTOR_W-1:0] r_avg_weight;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rise_factor <= RISE_FACTOR_RESET;
            r_fall_factor <= FALL_FACTOR_RESET;
            r_avg_weight  <= AVG_WEIGHT_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_RISE_FACTOR) r_rise_factor <= i_cfg_data;
            if (i_cfg_index == CFG_FALL_FACTOR) r_fall_factor <= i_cfg_data;
            if (i_cfg_index == CFG_AVG_WEIGHT)  r_avg_weight  <= i_cfg_data;
        end
    end

    // input register and result buffer control
    logic                       r_s_valid;
    logic signed [SAMPLE_W-1:0] r_s_sample;
    logic [1:0]                 r_q_count;
    t_result                    r_q0;
    t_result                    r_q1;

    logic w_fire;
    logic w_accept;
    logic w_push;
    logic w_pop;
    logic w_emit;

    assign w_fire   = r_s_valid && (r_q_count != 2'd2);
    assign o_stall  = r_s_valid && (r_q_count == 2'd2);
    assign w_accept = i_valid && !o_stall;
    assign w_pop    = o_valid && !i_stall;
    assign w_push   = w_fire && w_emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid <= 1'b0;
        end else if (w_accept) begin
            r_s_valid <= 1'b1;
        end else if (w_fire) begin
            r_s_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s_sample <= i_sample;
        end
    end

    // detector state
    logic                       r_searching;
    logic signed [AVG_W-1:0]    r_avg;
    logic signed [SAMPLE_W-1:0] r_best;
    logic [INDEX_W-1:0]         r_best_index;
    logic [INDEX_W-1:0]         r_count;

    // threshold products: sample in Q9.32 against average times factor
    logic signed [40:0] w_lhs;
    logic signed [40:0] w_rise_prod;
    logic signed [40:0] w_fall_prod;
    logic               w_above_rise;
    logic               w_above_fall;

    assign w_lhs        = {{5{r_s_sample[SAMPLE_W-1]}}, r_s_sample, 20'b0};
    assign w_rise_prod  = r_avg * $signed({1'b0, r_rise_factor});
    assign w_fall_prod  = r_avg * $signed({1'b0, r_fall_factor});
    assign w_above_rise = w_lhs > w_rise_prod;
    assign w_above_fall = w_lhs > w_fall_prod;

    // average update with round half up and saturation
    logic signed [25:0] w_diff;
    logic signed [42:0] w_step_prod;
    logic signed [42:0] w_step_rnd;
    logic signed [26:0] w_step;
    logic signed [27:0] w_sum;
    logic signed [AVG_W-1:0] w_avg_upd;

    assign w_diff      = {{2{r_s_sample[SAMPLE_W-1]}}, r_s_sample, 8'b0}
                         - {{2{r_avg[AVG_W-1]}}, r_avg};
    assign w_step_prod = w_diff * $signed({1'b0, r_avg_weight});
    assign w_step_rnd  = w_step_prod + 43'sd32768;
    assign w_step      = w_step_rnd[42:16];
    assign w_sum       = {{4{r_avg[AVG_W-1]}}, r_avg} + {w_step[26], w_step};

    always_comb begin
        if (w_sum[27:23] == 5'b00000 || w_sum[27:23] == 5'b11111) begin
            w_avg_upd = w_sum[AVG_W-1:0];
        end else if (w_sum[27]) begin
            w_avg_upd = AVG_MIN;
        end else begin
            w_avg_upd = AVG_MAX;
        end
    end

    // peak search decisions
    logic                       n_searching;
    logic signed [SAMPLE_W-1:0] n_best;
    logic [INDEX_W-1:0]         n_best_index;

    always_comb begin
        n_searching  = r_searching;
        n_best       = r_best;
        n_best_index = r_best_index;
        w_emit       = 1'b0;
        if (r_searching && (r_s_sample > r_best)) begin
            n_best       = r_s_sample;
            n_best_index = r_count;
        end else if (r_searching && w_above_fall) begin
            n_best = r_best;
        end else begin
            // search ends here, then the same sample is judged as idle
            if (r_searching) begin
                w_emit      = 1'b1;
                n_searching = 1'b0;
                n_best      = BEST_RESET;
            end
            if (w_above_rise) begin
                n_searching  = 1'b1;
                n_best       = r_s_sample;
                n_best_index = r_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_searching  <= 1'b0;
            r_avg        <= AVG_RESET;
            r_best       <= BEST_RESET;
            r_best_index <= '0;
            r_count      <= '0;
        end else if (w_fire) begin
            r_searching  <= n_searching;
            r_avg        <= w_avg_upd;
            r_best       <= n_best;
            r_best_index <= n_best_index;
            r_count      <= r_count + 32'd1;
        end
    end

    // two-entry result buffer, head drives the outputs
    t_result    w_new;
    t_result    n_q0;
    t_result    n_q1;
    logic [1:0] n_q_count;

    assign w_new.peak_index = r_best_index;
    assign w_new.peak_value = r_best;

    always_comb begin
        n_q0 = r_q0;
        n_q1 = r_q1;
        if (w_pop) begin
            if (r_q_count == 2'd2) begin
                n_q0 = r_q1;
                if (w_push) n_q1 = w_new;
            end else if (w_push) begin
                n_q0 = w_new;
            end
        end else if (w_push) begin
            if (r_q_count == 2'd0) n_q0 = w_new;
            else                   n_q1 = w_new;
        end
        n_q_count = r_q_count + {1'b0, w_push} - {1'b0, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_count <= 2'd0;
        end else begin
            r_q_count <= n_q_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q0 <= n_q0;
        r_q1 <= n_q1;
    end

    assign o_valid      = (r_q_count != 2'd0);
    assign o_peak_index = r_q0.peak_index;
    assign o_peak_value = r_q0.peak_value;

    // checks
    `TPD_ASSERT_NEVER(a_q_overflow, i_clk, i_rst_n, r_q_count == 2'd3)
    `TPD_ASSERT(a_q_drain, i_clk, i_rst_n, (w_pop && !w_push && r_q_count == 2'd1) |=> !o_valid)
    `TPD_ASSERT(a_search_start, i_clk, i_rst_n, $rose(r_searching) |-> $past(w_fire))
    `TPD_ASSERT(a_count_step, i_clk, i_rst_n, w_fire |=> (r_count == $past(r_count) + 32'd1))

endmodule

`default_nettype wire
